// ===== hdl/gtm_pkg.sv =====
package gtm_pkg;

    // table geometry
    localparam int NODES          = 256;
    localparam int SLOTS_PER_NODE = 8;
    localparam int NODE_W         = $clog2(NODES);
    localparam int SLOT_W         = $clog2(SLOTS_PER_NODE);
    localparam int TBL_DEPTH      = NODES * SLOTS_PER_NODE;
    localparam int TBL_AW         = $clog2(TBL_DEPTH);

    // one stored slot, address in the lowest bits
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  hw_type;
        logic [7:0]  hw_address;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // result status codes
    typedef enum logic [2:0] {
        STAT_REFRESH  = 3'd0,
        STAT_FILLED   = 3'd1,
        STAT_REPLACED = 3'd2,
        STAT_READ     = 3'd3,
        STAT_REJECT   = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_RESP
    } state_t;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic              start;
        logic              beat;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        key_address;
        logic [7:0]        key_type;
    } scan_ctrl_t;

    // outcome of a group scan
    typedef struct packed {
        logic              have_match;
        logic              have_free;
        logic              have_old;
        logic [SLOT_W-1:0] match_slot;
        logic [SLOT_W-1:0] free_slot;
        logic [SLOT_W-1:0] old_slot;
    } scan_res_t;

endpackage

// ===== hdl/gtm_ram.sv =====
module gtm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/gtm_scan.sv =====
module gtm_scan
    import gtm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  scan_ctrl_t ctrl,
    input  entry_t     rd_entry,
    output scan_res_t  res
);

    logic              have_match_reg, have_match_next;
    logic              have_free_reg,  have_free_next;
    logic              have_old_reg,   have_old_next;
    logic [SLOT_W-1:0] match_slot_reg, match_slot_next;
    logic [SLOT_W-1:0] free_slot_reg,  free_slot_next;
    logic [SLOT_W-1:0] old_slot_reg,   old_slot_next;
    logic [31:0]       old_stamp_reg,  old_stamp_next;
    logic              empty;
    logic              same;

    assign empty = (rd_entry.hw_address == 8'd0) && (rd_entry.hw_type == 8'd0);
    assign same  = (rd_entry.hw_address == ctrl.key_address) &&
                   (rd_entry.hw_type == ctrl.key_type);

    // fold one slot per beat into the running match / free / oldest picks
    always_comb begin
        have_match_next = have_match_reg;
        have_free_next  = have_free_reg;
        have_old_next   = have_old_reg;
        match_slot_next = match_slot_reg;
        free_slot_next  = free_slot_reg;
        old_slot_next   = old_slot_reg;
        old_stamp_next  = old_stamp_reg;
        if (ctrl.start) begin
            have_match_next = 1'b0;
            have_free_next  = 1'b0;
            have_old_next   = 1'b0;
        end else if (ctrl.beat && !have_match_reg) begin
            if (empty) begin
                if (!have_free_reg) begin
                    have_free_next = 1'b1;
                    free_slot_next = ctrl.slot;
                end
            end else if (same) begin
                have_match_next = 1'b1;
                match_slot_next = ctrl.slot;
            end else if (!have_old_reg || (rd_entry.stamp < old_stamp_reg)) begin
                have_old_next  = 1'b1;
                old_slot_next  = ctrl.slot;
                old_stamp_next = rd_entry.stamp;
            end
        end
    end

    // flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_match_reg <= 1'b0;
            have_free_reg  <= 1'b0;
            have_old_reg   <= 1'b0;
        end else begin
            have_match_reg <= have_match_next;
            have_free_reg  <= have_free_next;
            have_old_reg   <= have_old_next;
        end
    end

    // slot picks and oldest stamp
    always_ff @(posedge aclk) begin
        match_slot_reg <= match_slot_next;
        free_slot_reg  <= free_slot_next;
        old_slot_reg   <= old_slot_next;
        old_stamp_reg  <= old_stamp_next;
    end

    assign res.have_match = have_match_reg;
    assign res.have_free  = have_free_reg;
    assign res.have_old   = have_old_reg;
    assign res.match_slot = match_slot_reg;
    assign res.free_slot  = free_slot_reg;
    assign res.old_slot   = old_slot_reg;

    // a match ends the scan: nothing changes once it is seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        (have_match_reg && !ctrl.start) |=> (match_slot_reg == $past(match_slot_reg)))
        else $error("match slot changed after match");

    // the first free slot is never overwritten by a later one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (have_free_reg && !ctrl.start) |=> (free_slot_reg == $past(free_slot_reg)))
        else $error("free slot changed after first free seen");

    // a fresh scan starts with nothing found
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |=> (!have_match_reg && !have_free_reg && !have_old_reg))
        else $error("scan state not cleared on start");

endmodule

// ===== hdl/grouped_table_match_free_oldest_core.sv =====
// Slot table of 256 node groups with 8 slots each, held in one 2048 x 48 bit
// synchronous RAM. After reset the core clears all 2048 slots, one per cycle,
// and holds s_tready low until it is done. Items are
// handled one at a time, and the RAM's single read port sets the pace: an
// update reads the 8 slots of its group one per cycle, then writes the chosen
// slot; a read of one slot waits for its RAM data; a rejected zero pair or a
// read beyond the group goes straight to the response. The next item is
// accepted in the cycle after the result has been moved into the output
// register, even while that result waits on m_tready.
module grouped_table_match_free_oldest_core
    import gtm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // node_id, hw_address, hw_type, stamp, slot_index
    input  logic [0:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // slot_used, entry_address, entry_type, entry_stamp
    output logic [2:0]  m_tuser   // status
);

    state_t            state_reg, state_next;
    logic [TBL_AW-1:0] clr_reg, clr_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              beat_reg, beat_next;
    logic [SLOT_W-1:0] beat_slot_reg, beat_slot_next;

    logic              op_reg, op_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [2:0]        sidx_reg, sidx_next;
    entry_t            key_reg, key_next;

    status_t           res_status_reg, res_status_next;
    logic [2:0]        res_slot_reg, res_slot_next;
    entry_t            res_entry_reg, res_entry_next;

    logic              m_tvalid_reg, m_tvalid_next;
    status_t           m_status_reg, m_status_next;
    logic [2:0]        m_slot_reg, m_slot_next;
    entry_t            m_entry_reg, m_entry_next;

    // input beat fields
    logic              in_op;
    logic [7:0]        in_node;
    logic [7:0]        in_address;
    logic [7:0]        in_type;
    logic [31:0]       in_stamp;
    logic [2:0]        in_slot;
    logic              accept;
    logic              out_free;
    logic              in_zero_pair;
    logic              in_slot_beyond;

    // memory and scan connections
    logic              ram_wr_en;
    logic [TBL_AW-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    logic [TBL_AW-1:0] ram_rd_addr;
    entry_t            ram_rd_data;
    scan_ctrl_t        scan_ctrl;
    scan_res_t         scan_res;
    logic [SLOT_W-1:0] dec_slot;
    status_t           dec_status;

    assign in_op      = s_tuser[0];
    assign in_node    = s_tdata[7:0];
    assign in_address = s_tdata[15:8];
    assign in_type    = s_tdata[23:16];
    assign in_stamp   = s_tdata[55:24];
    assign in_slot    = s_tdata[58:56];

    assign accept         = s_tvalid && s_tready;
    assign out_free       = !m_tvalid_reg || m_tready;
    assign in_zero_pair   = (in_address == 8'd0) && (in_type == 8'd0);
    assign in_slot_beyond = (32'(in_slot) >= SLOTS_PER_NODE);

    // slot table storage
    gtm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // running match / free / oldest search over the group
    gtm_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (scan_ctrl),
        .rd_entry (ram_rd_data),
        .res      (scan_res)
    );

    // pick the slot to write after the scan
    always_comb begin
        priority if (scan_res.have_match) begin
            dec_slot   = scan_res.match_slot;
            dec_status = STAT_REFRESH;
        end else if (scan_res.have_free) begin
            dec_slot   = scan_res.free_slot;
            dec_status = STAT_FILLED;
        end else begin
            dec_slot   = scan_res.old_slot;
            dec_status = STAT_REPLACED;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == TBL_AW'(TBL_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_op) begin
                        state_next = in_slot_beyond ? ST_RESP : ST_READ;
                    end else begin
                        state_next = in_zero_pair ? ST_RESP : ST_SCAN;
                    end
                end
            end
            ST_READ: state_next = ST_WAIT;
            ST_SCAN: begin
                if (cnt_reg == SLOT_W'(SLOTS_PER_NODE - 1)) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:   state_next = op_reg ? ST_RESP : ST_DECIDE;
            ST_DECIDE: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // state outputs: handshake, memory ports, scan control
    always_comb begin
        s_tready    = (state_reg == ST_IDLE);
        ram_rd_en   = (state_reg == ST_READ) || (state_reg == ST_SCAN);
        ram_rd_addr = {node_reg, (state_reg == ST_READ) ? sidx_reg[SLOT_W-1:0] : cnt_reg};
        ram_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_DECIDE);
        if (state_reg == ST_CLEAR) begin
            ram_wr_addr = clr_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_addr = {node_reg, dec_slot};
            ram_wr_data = key_reg;
        end
        scan_ctrl.start       = accept;
        scan_ctrl.beat        = beat_reg;
        scan_ctrl.slot        = beat_slot_reg;
        scan_ctrl.key_address = key_reg.hw_address;
        scan_ctrl.key_type    = key_reg.hw_type;
    end

    // datapath next values
    always_comb begin
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        beat_next       = (state_reg == ST_SCAN);
        beat_slot_next  = cnt_reg;
        op_next         = op_reg;
        node_next       = node_reg;
        sidx_next       = sidx_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_entry_next  = res_entry_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_entry_next    = m_entry_reg;

        // clearing sweep
        if (state_reg == ST_CLEAR) begin
            clr_next = clr_reg + TBL_AW'(1);
        end

        // capture the item; answer rejects and out-of-group reads at once
        if (accept) begin
            op_next            = in_op;
            node_next          = NODE_W'(32'(in_node) % NODES);
            sidx_next          = in_slot;
            key_next.hw_address = in_address;
            key_next.hw_type    = in_type;
            key_next.stamp      = in_stamp;
            cnt_next           = '0;
            if (in_op) begin
                res_status_next = STAT_READ;
                res_slot_next   = in_slot;
                res_entry_next  = '0;
            end else begin
                res_status_next = STAT_REJECT;
                res_slot_next   = 3'd0;
                res_entry_next  = '0;
            end
        end

        // slot read issue counter
        if (state_reg == ST_SCAN) begin
            cnt_next = cnt_reg + SLOT_W'(1);
        end

        // read data arrives
        if ((state_reg == ST_WAIT) && op_reg) begin
            res_status_next = STAT_READ;
            res_slot_next   = sidx_reg;
            res_entry_next  = ram_rd_data;
        end

        // update written back
        if (state_reg == ST_DECIDE) begin
            res_status_next = dec_status;
            res_slot_next   = 3'(dec_slot);
            res_entry_next  = key_reg;
        end

        // output register
        if ((state_reg == ST_RESP) && out_free) begin
            m_tvalid_next = 1'b1;
            m_status_next = res_status_reg;
            m_slot_next   = res_slot_reg;
            m_entry_next  = res_entry_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            beat_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cnt_reg      <= cnt_next;
            beat_reg     <= beat_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        beat_slot_reg  <= beat_slot_next;
        op_reg         <= op_next;
        node_reg       <= node_next;
        sidx_reg       <= sidx_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_entry_reg  <= res_entry_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_entry_reg    <= m_entry_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'd0, m_entry_reg.stamp, m_entry_reg.hw_type,
                       m_entry_reg.hw_address, m_slot_reg};

    // a full group with no match must have an oldest candidate
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DECIDE) && !scan_res.have_match && !scan_res.have_free)
        |-> scan_res.have_old)
        else $error("replacement with no oldest slot");

    // the table is written only by the clearing sweep or an update
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> ((state_reg == ST_CLEAR) || (state_reg == ST_DECIDE)))
        else $error("unexpected table write");

    // no item is taken during the clearing sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted while clearing");

    // a result leaving the response state shows up as a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RESP) && out_free) |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("result not presented");

endmodule
